// File: sv/prs_pkg.sv
// ============================================================================
// prs_pkg
// Shared types and constants of the text-to-integer parser.
// ============================================================================
package prs_pkg;

    // Saturation limit of the consumed-character count.
    localparam int OFFSET_LIMIT = 65535;
    localparam int CNT_W        = $clog2(OFFSET_LIMIT + 1);
    localparam int OFF_W        = 16;
    localparam int VAL_W        = 64;
    localparam int NARROW_W     = 32;
    localparam int CH_W         = 8;
    localparam int BASE_W       = 6;

    // Stream payload widths.
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 80;

    // Depth of the queue between the front and the back.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Character constants.
    localparam logic [CH_W-1:0] CH_DIGIT0   = 8'h30; // '0'
    localparam logic [CH_W-1:0] CH_DIGIT7   = 8'h37; // '7'
    localparam logic [CH_W-1:0] CH_DIGIT9   = 8'h39; // '9'
    localparam logic [CH_W-1:0] CH_UPPER_A  = 8'h41; // 'A'
    localparam logic [CH_W-1:0] CH_UPPER_F  = 8'h46; // 'F'
    localparam logic [CH_W-1:0] CH_LOWER_A  = 8'h61; // 'a'
    localparam logic [CH_W-1:0] CH_LOWER_F  = 8'h66; // 'f'
    localparam logic [CH_W-1:0] CH_UPPER_OF = 8'h37; // 'A' - 10
    localparam logic [CH_W-1:0] CH_LOWER_OF = 8'h57; // 'a' - 10
    localparam logic [CH_W-1:0] CH_X        = 8'h78; // 'x'
    localparam logic [CH_W-1:0] CH_MINUS    = 8'h2D; // '-'
    localparam logic [CH_W-1:0] CH_PLUS     = 8'h2B; // '+'
    localparam logic [CH_W-1:0] CH_SPACE    = 8'h20; // ' '
    localparam logic [CH_W-1:0] CH_TAB      = 8'h09; // TAB
    localparam logic [CH_W-1:0] CH_CR       = 8'h0D; // CR

    // Requested base codes.
    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

    typedef enum logic [1:0] {
        RDX_AUTO,
        RDX_8,
        RDX_10,
        RDX_16
    } radix_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_PREFIX,
        PH_ZERO,
        PH_DIGITS
    } phase_t;

    // One classified character, as it travels from the front to the back.
    typedef struct packed {
        logic       start;
        logic       bad_base;
        radix_t     radix;
        logic       wide;
        logic       space;
        logic       sign;
        logic       minus;
        logic       zero;
        logic       x;
        logic       dec;
        logic       oct;
        logic       hex;
        logic [3:0] dig;
    } prs_item_t;

endpackage

// File: sv/prs_front.sv
// ============================================================================
// prs_front
// Classifies each incoming character and decodes the requested base.
// ============================================================================
module prs_front
(
    input  logic [prs_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                         s_tuser,
    output prs_pkg::prs_item_t           item
);
    import prs_pkg::*;

    logic [CH_W-1:0]   ch;
    logic [BASE_W-1:0] base_mode;
    logic              is_upper;
    logic              is_lower;
    logic [CH_W-1:0]   dig_full;

    assign ch        = s_tdata[CH_W-1:0];
    assign base_mode = s_tdata[CH_W+BASE_W-1:CH_W];

    assign is_upper = (ch >= CH_UPPER_A) && (ch <= CH_UPPER_F);
    assign is_lower = (ch >= CH_LOWER_A) && (ch <= CH_LOWER_F);

    always_comb
    begin
        if (is_upper)
        begin
            dig_full = ch - CH_UPPER_OF;
        end
        else if (is_lower)
        begin
            dig_full = ch - CH_LOWER_OF;
        end
        else
        begin
            dig_full = ch - CH_DIGIT0;
        end
    end

    always_comb
    begin
        item.start    = s_tuser;
        item.wide     = s_tdata[CH_W+BASE_W];
        item.bad_base = 1'b0;
        unique case (base_mode)
            BASE_AUTO: item.radix = RDX_AUTO;
            BASE_OCT:  item.radix = RDX_8;
            BASE_DEC:  item.radix = RDX_10;
            BASE_HEX:  item.radix = RDX_16;
            default:
            begin
                item.radix    = RDX_AUTO;
                item.bad_base = 1'b1;
            end
        endcase
        item.space = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
        item.sign  = (ch == CH_MINUS) || (ch == CH_PLUS);
        item.minus = (ch == CH_MINUS);
        item.zero  = (ch == CH_DIGIT0);
        item.x     = (ch == CH_X);
        item.dec   = (ch >= CH_DIGIT0) && (ch <= CH_DIGIT9);
        item.oct   = (ch >= CH_DIGIT0) && (ch <= CH_DIGIT7);
        item.hex   = item.dec || is_upper || is_lower;
        item.dig   = dig_full[3:0];
    end

endmodule

// File: sv/prs_queue.sv
// ============================================================================
// prs_queue
// Short first-in first-out queue of classified items.
// ============================================================================
module prs_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  prs_pkg::prs_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output prs_pkg::prs_item_t head_item
);
    import prs_pkg::*;

    prs_item_t       mem_reg [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg;
    logic [Q_AW-1:0] wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg;
    logic [Q_AW-1:0] rd_ptr_next;
    logic [Q_AW:0]   fill_reg;
    logic [Q_AW:0]   fill_next;

    assign full      = (fill_reg == (Q_AW + 1)'(Q_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: sv/prs_back.sv
// ============================================================================
// prs_back
// Conversion state machine and registered result output.
// ============================================================================
module prs_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    input  prs_pkg::prs_item_t           q_item,
    output logic                         q_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [prs_pkg::M_DATA_W-1:0] m_tdata,
    output logic                         m_tuser
);
    import prs_pkg::*;

    localparam int CMP_W = (CNT_W > OFF_W) ? CNT_W : OFF_W;
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(OFFSET_LIMIT);
    localparam logic [CMP_W-1:0] OFF_MAX   = {{(CMP_W - OFF_W){1'b0}}, {OFF_W{1'b1}}};

    phase_t           phase_reg, phase_next;
    radix_t           radix_reg, radix_next;
    logic             neg_reg, neg_next;
    logic [VAL_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             wide_reg, wide_next;

    logic             out_valid_reg;
    logic [VAL_W-1:0] out_value_reg, out_value_next;
    logic [OFF_W-1:0] out_off_reg, out_off_next;
    logic             out_bad_reg, out_bad_next;

    // Working copy of the state once a start has been applied.
    phase_t           ph;
    radix_t           rdx;
    logic             neg;
    logic [VAL_W-1:0] acc;
    logic [CNT_W-1:0] cnt;
    logic             wid;
    logic [CNT_W-1:0] cnt_inc;
    logic             do_digit;
    radix_t           dig_radix;
    logic             dig_ok;
    logic [VAL_W-1:0] acc_mul;
    logic [VAL_W-1:0] acc_sum;
    logic [VAL_W-1:0] val_neg;
    logic [CMP_W-1:0] cnt_cmp;
    logic             emit;

    assign q_pop = q_valid && (!out_valid_reg || m_tready);

    always_comb
    begin
        ph  = phase_reg;
        rdx = radix_reg;
        neg = neg_reg;
        acc = acc_reg;
        cnt = cnt_reg;
        wid = wide_reg;
        if (q_item.start)
        begin
            ph  = PH_LEAD;
            rdx = q_item.radix;
            neg = 1'b0;
            acc = '0;
            cnt = '0;
            wid = q_item.wide;
        end

        cnt_inc = (cnt == CNT_LIMIT) ? cnt : cnt + 1'b1;

        // Value and offset of a result, should this character stop the run.
        val_neg = neg ? (VAL_W'(0) - acc) : acc;
        if (!wid)
        begin
            val_neg = {{(VAL_W - NARROW_W){val_neg[NARROW_W-1]}}, val_neg[NARROW_W-1:0]};
        end
        cnt_cmp = CMP_W'(cnt);

        phase_next     = phase_reg;
        radix_next     = radix_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        wide_next      = wide_reg;
        emit           = 1'b0;
        do_digit       = 1'b0;
        dig_radix      = rdx;
        dig_ok         = 1'b0;
        acc_mul        = '0;
        acc_sum        = '0;
        out_value_next = val_neg;
        out_off_next   = (cnt_cmp > OFF_MAX) ? OFF_W'(OFF_MAX) : OFF_W'(cnt_cmp);
        out_bad_next   = 1'b0;

        if (q_pop)
        begin
            phase_next = ph;
            radix_next = rdx;
            neg_next   = neg;
            acc_next   = acc;
            cnt_next   = cnt;
            wide_next  = wid;

            if (q_item.start && q_item.bad_base)
            begin
                emit           = 1'b1;
                out_value_next = '0;
                out_off_next   = '0;
                out_bad_next   = 1'b1;
                phase_next     = PH_IDLE;
            end
            else
            begin
                unique case (ph)
                    PH_IDLE:
                    begin
                        phase_next = PH_IDLE;
                    end
                    PH_LEAD, PH_PREFIX:
                    begin
                        if ((ph == PH_LEAD) && q_item.space)
                        begin
                            cnt_next = cnt_inc;
                        end
                        else if ((ph == PH_LEAD) && q_item.sign)
                        begin
                            neg_next   = q_item.minus;
                            cnt_next   = cnt_inc;
                            phase_next = PH_PREFIX;
                        end
                        else if ((rdx == RDX_AUTO) && q_item.zero)
                        begin
                            cnt_next   = cnt_inc;
                            phase_next = PH_ZERO;
                        end
                        else
                        begin
                            do_digit  = 1'b1;
                            dig_radix = (rdx == RDX_AUTO) ? RDX_10 : rdx;
                        end
                    end
                    PH_ZERO:
                    begin
                        if (q_item.x)
                        begin
                            radix_next = RDX_16;
                            cnt_next   = cnt_inc;
                            phase_next = PH_DIGITS;
                        end
                        else
                        begin
                            do_digit  = 1'b1;
                            dig_radix = q_item.dec ? RDX_8 : RDX_10;
                        end
                    end
                    PH_DIGITS:
                    begin
                        do_digit = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase

                if (do_digit)
                begin
                    radix_next = dig_radix;
                    case (dig_radix)
                        RDX_8:
                        begin
                            dig_ok  = q_item.oct;
                            acc_mul = acc << 3;
                        end
                        RDX_10:
                        begin
                            dig_ok  = q_item.dec;
                            acc_mul = (acc << 3) + (acc << 1);
                        end
                        RDX_16:
                        begin
                            dig_ok  = q_item.hex;
                            acc_mul = acc << 4;
                        end
                        default:
                        begin
                            dig_ok  = 1'b0;
                            acc_mul = acc;
                        end
                    endcase
                    acc_sum = acc_mul + VAL_W'(q_item.dig);
                    if (!wid)
                    begin
                        acc_sum = {{(VAL_W - NARROW_W){1'b0}}, acc_sum[NARROW_W-1:0]};
                    end
                    if (dig_ok)
                    begin
                        acc_next   = acc_sum;
                        cnt_next   = cnt_inc;
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        emit       = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            radix_reg     <= RDX_AUTO;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            wide_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            radix_reg <= radix_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            wide_reg  <= wide_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_value_reg <= out_value_next;
            out_off_reg   <= out_off_next;
            out_bad_reg   <= out_bad_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_off_reg, out_value_reg};
    assign m_tuser  = out_bad_reg;

endmodule

// File: sv/text_to_integer_parser_core.sv
// ============================================================================
// text_to_integer_parser_core
// Streaming ASCII-to-integer converter with base detection and sign.
// ============================================================================
// A result passes through the queue and then the output register after the
// stopping character is accepted.
// Throughput: one character per cycle while the result stream flows, set by the
// combinational shift-add of the back end; the queue holds four items on a stall.
// Reset (rst_n, asynchronous, active low) empties the queue, drops any
// pending result and returns the conversion state to idle.
// ============================================================================
module text_to_integer_parser_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    // Input stream.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [prs_pkg::S_DATA_W-1:0] s_tdata,  // ch[7:0], base_mode[13:8], wide[14], 0[15]
    input  logic                         s_tuser,  // start_req
    // Result stream.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [prs_pkg::M_DATA_W-1:0] m_tdata,  // value[63:0], end_offset[79:64]
    output logic                         m_tuser   // bad_base
);
    import prs_pkg::*;

    // The front end classifies each character as it arrives: whitespace,
    // sign, prefix characters and digit classes for each supported base.
    // The requested base is decoded here too, so the back end never sees
    // the raw base field.
    prs_item_t front_item;
    prs_item_t head_item;
    logic      q_full;
    logic      q_not_empty;
    logic      q_pop;
    logic      q_push;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    prs_front u_front
    (
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .item    (front_item)
    );

    // The queue decouples intake from conversion, so that a stalled result
    // stream does not stop characters from being accepted at once.
    prs_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    // The back end runs the conversion: it skips leading whitespace, takes
    // the sign, detects the base from a prefix in automatic mode and then
    // accumulates digits with wraparound at 32 or 64 bits. It takes one
    // item per cycle whenever its output register is free or being emptied.
    prs_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_not_empty),
        .q_item   (head_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
